@@ rtl/running_regression_leak_detector_defines.svh @@
// Assertion macros for the leak detector checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef RUNNING_REGRESSION_LEAK_DETECTOR_DEFINES_SVH
`define RUNNING_REGRESSION_LEAK_DETECTOR_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define RRLD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define RRLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/rrld_pkg.sv @@
// Shared constants, register codes and helpers for the leak detector.
// No dependencies.
package rrld_pkg;

    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int HIT_BITS       = 16;
    localparam int HIT_THR_BITS   = 16;
    localparam int SLOPE_THR_BITS = 24;
    localparam int TOL_BITS       = 10;
    localparam int CFG_ADDR_BITS  = 4;
    localparam int CFG_DATA_BITS  = 32;
    localparam int PERMILLE       = 1000;

    localparam logic [HIT_THR_BITS-1:0]   HIT_THR_RST   = 16'd20;
    localparam logic [SLOPE_THR_BITS-1:0] SLOPE_THR_RST = 24'd200;
    localparam logic [TOL_BITS-1:0]       TOL_RST       = 10'd100;

    typedef enum logic [1:0] {
        REG_HIT_THR   = 2'd0,
        REG_SLOPE_THR = 2'd1,
        REG_TOL       = 2'd2
    } t_reg_idx;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/rrld_if.sv @@
// Valid/ready channel interfaces for the leak detector.
// Depends on rrld_pkg for default widths.
interface rrld_in_if import rrld_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] usage_sample;

    modport source(output valid, output usage_sample, input ready);
    modport sink(input valid, input usage_sample, output ready);
endinterface

interface rrld_out_if import rrld_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
);
    logic                                   valid;
    logic                                   ready;
    logic                                   leak_warning;
    logic [SAMPLE_BITS-1:0]                 predicted_next;
    logic signed [SAMPLE_BITS+FRACTION_BITS:0] slope_q16;
    logic [HIT_BITS-1:0]                    hit_count;
    logic                                   count_saturated;

    modport source(output valid, output leak_warning, output predicted_next,
                   output slope_q16, output hit_count, output count_saturated,
                   input ready);
    modport sink(input valid, input leak_warning, input predicted_next,
                 input slope_q16, input hit_count, input count_saturated,
                 output ready);
endinterface

@@ rtl/rrld_mul.sv @@
// Serial shift-add multiplier: one multiplier bit per cycle, early stop.
// No dependencies; product is taken modulo 2^P_W (A may be sign-extended).
module rrld_mul #(
    parameter int P_W = 8,
    parameter int B_W = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [P_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_done,
    output logic [P_W-1:0] o_p
);
    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [P_W-1:0] r_a, n_a;
    logic [B_W-1:0] r_b, n_b;
    logic [P_W-1:0] r_acc, n_acc;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_b == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = r_a << 1;
                n_b = r_b >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

@@ rtl/rrld_div.sv @@
// Restoring divider: one quotient bit per cycle, P_W steps.
// No dependencies; unsigned numerator and nonzero unsigned denominator.
module rrld_div #(
    parameter int P_W = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [P_W-1:0] i_num,
    input  logic [P_W-1:0] i_den,
    output logic           o_done,
    output logic [P_W-1:0] o_q
);
    localparam int CNT_W = $clog2(P_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [P_W-1:0]   r_q, n_q;
    logic [P_W-1:0]   r_rem, n_rem;
    logic [P_W-1:0]   r_den, n_den;
    logic [P_W:0]     trial;
    logic [P_W:0]     diff;

    assign trial = {r_rem, r_q[P_W-1]};
    assign diff  = trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(P_W);
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
                if (!diff[P_W]) begin
                    n_rem = diff[P_W-1:0];
                    n_q   = {r_q[P_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[P_W-1:0];
                    n_q   = {r_q[P_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

@@ rtl/running_regression_leak_detector.sv @@
// Running least-squares leak detector: sequencer, sums, hit check, outputs.
// Depends on rrld_pkg, rrld_if.sv, rrld_mul and rrld_div.
//
//  channel    dir  handshake            payload
//  i_sample   in   valid/ready          usage_sample
//  o_result   out  valid/ready          leak_warning, predicted_next,
//                                       slope_q16, hit_count, count_saturated
//  apb        in   psel/penable/pwrite  paddr, pwdata -> prdata
//
// One sample is in work at a time. Sequencing steps are accept, sum update and
// result load; each serial multiply stops early once its multiplier operand is
// used up, and each restoring divide works at the width W (W = SAMPLE_BITS
// + 3*COUNT_BITS + max(COUNT_BITS+2, FRACTION_BITS) + 1, 91 at default widths).
// With a prediction: ten multiplies and three divides; a zero denominator stops
// after the sums. Synchronous active-low reset clears count, sums, prediction,
// slope, hits, warning and output valid and loads the config registers with their
// defaults; no clearing pass. A new sample is taken while the previous result
// waits on o_result; the next result then waits for the slot.
module running_regression_leak_detector import rrld_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    rrld_in_if.sink                  i_sample,
    rrld_out_if.source               o_result
);
    localparam int SLOPE_BITS = SAMPLE_BITS + FRACTION_BITS + 1;
    localparam int SX_W  = 2 * COUNT_BITS;
    localparam int SY_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int SXX_W = 3 * COUNT_BITS;
    localparam int SXY_W = SAMPLE_BITS + 2 * COUNT_BITS;
    // working width: holds an << F and an*(N+1) + bn with sign
    localparam int W = SAMPLE_BITS + 3 * COUNT_BITS
                       + max2(COUNT_BITS + 2, FRACTION_BITS) + 1;
    localparam int MB_W = max2(max2(SY_W, SX_W), TOL_BITS);
    localparam int CMP_W = max2(SLOPE_BITS, SLOPE_THR_BITS + FRACTION_BITS) + 1;

    localparam logic [W-1:0] SLOPE_LIM = W'(1) << (SLOPE_BITS - 1);
    localparam logic [W-1:0] SAMPLE_MAX_W = (W'(1) << SAMPLE_BITS) - W'(1);
    localparam logic signed [SLOPE_BITS-1:0] SLOPE_MAX = {1'b0, {(SLOPE_BITS-1){1'b1}}};
    localparam logic signed [SLOPE_BITS-1:0] SLOPE_MIN = {1'b1, {(SLOPE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE, S_UPD, S_RUN, S_WAIT, S_OUT
    } t_state;

    // serial operation steps, in issue order
    typedef enum logic [3:0] {
        OP_TOLM, OP_TOLD, OP_XX, OP_XY, OP_D1, OP_D2, OP_A1, OP_A2,
        OP_B1, OP_B2, OP_SD, OP_PM, OP_PD
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    // configuration
    logic [HIT_THR_BITS-1:0]   r_hthr, n_hthr;
    logic [SLOPE_THR_BITS-1:0] r_sthr, n_sthr;
    logic [TOL_BITS-1:0]       r_tol, n_tol;

    // detector state
    logic [COUNT_BITS-1:0]        r_count, n_count;
    logic [SX_W-1:0]              r_sx, n_sx;
    logic [SY_W-1:0]              r_sy, n_sy;
    logic [SXX_W-1:0]             r_sxx, n_sxx;
    logic [SXY_W-1:0]             r_sxy, n_sxy;
    logic [SAMPLE_BITS-1:0]       r_pred, n_pred;
    logic signed [SLOPE_BITS-1:0] r_slope, n_slope;
    logic [HIT_BITS-1:0]          r_hits, n_hits;
    logic                         r_warn, n_warn;

    // per-sample working registers
    logic [SAMPLE_BITS-1:0] r_y, n_y;
    logic [W-1:0]           r_t, n_t;
    logic [W-1:0]           r_d, n_d;
    logic [W-1:0]           r_an, n_an;
    logic [W-1:0]           r_bn, n_bn;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic                         r_o_warn, n_o_warn;
    logic [SAMPLE_BITS-1:0]       r_o_pred, n_o_pred;
    logic signed [SLOPE_BITS-1:0] r_o_slope, n_o_slope;
    logic [HIT_BITS-1:0]          r_o_hits, n_o_hits;
    logic                         r_o_sat, n_o_sat;

    // shared units
    logic           mul_start, mul_done, div_start, div_done, is_div;
    logic [W-1:0]   mul_a, mul_p, div_num, div_den, div_q;
    logic [MB_W-1:0] mul_b;

    logic           in_acc, cfg_wr;
    t_reg_idx       cfg_idx;
    logic [COUNT_BITS-1:0] x_next;
    logic [W-1:0]   an_mag, t_mag, pred_w, y_w, lo_w, hi_w, d_new;
    logic           hit;
    logic [HIT_BITS-1:0] hits_inc;
    logic signed [CMP_W-1:0] slope_c;
    logic [CMP_W-1:0] thr_c;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = t_reg_idx'(paddr[CFG_ADDR_BITS-1:2]);
    assign in_acc   = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == S_IDLE);

    always_comb begin
        case (cfg_idx)
            REG_HIT_THR:   prdata = CFG_DATA_BITS'(r_hthr);
            REG_SLOPE_THR: prdata = CFG_DATA_BITS'(r_sthr);
            REG_TOL:       prdata = CFG_DATA_BITS'(r_tol);
            default:       prdata = '0;
        endcase
    end

    assign x_next = r_count + 1'b1;
    assign an_mag = r_an[W-1] ? (~r_an + 1'b1) : r_an;
    assign t_mag  = r_t[W-1] ? (~r_t + 1'b1) : r_t;
    assign is_div = (r_op == OP_TOLD) || (r_op == OP_SD) || (r_op == OP_PD);
    assign mul_start = (r_state == S_RUN) && !is_div;
    assign div_start = (r_state == S_RUN) && is_div;

    // operand select per step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = r_d;
        case (r_op)
            OP_TOLM: begin mul_a = W'(r_pred); mul_b = MB_W'(r_tol); end
            OP_TOLD: begin div_num = r_t; div_den = W'(PERMILLE); end
            OP_XX:   begin mul_a = W'(r_count); mul_b = MB_W'(r_count); end
            OP_XY:   begin mul_a = W'(r_y); mul_b = MB_W'(r_count); end
            OP_D1:   begin mul_a = W'(r_sxx); mul_b = MB_W'(r_count); end
            OP_D2:   begin mul_a = W'(r_sx); mul_b = MB_W'(r_sx); end
            OP_A1:   begin mul_a = W'(r_sxy); mul_b = MB_W'(r_count); end
            OP_A2:   begin mul_a = W'(r_sy); mul_b = MB_W'(r_sx); end
            OP_B1:   begin mul_a = W'(r_sxx); mul_b = MB_W'(r_sy); end
            OP_B2:   begin mul_a = W'(r_sxy); mul_b = MB_W'(r_sx); end
            OP_SD:   begin div_num = an_mag << FRACTION_BITS; end
            OP_PM:   begin mul_a = r_an; mul_b = MB_W'(r_count) + 1'b1; end
            OP_PD:   begin div_num = t_mag; end
            default: begin mul_a = '0; end
        endcase
    end

    // hit window around the old prediction; err comes from the divider
    assign pred_w   = W'(r_pred);
    assign y_w      = W'(r_y);
    assign lo_w     = (pred_w > div_q) ? (pred_w - div_q) : '0;
    assign hi_w     = pred_w + div_q;
    assign hit      = (y_w >= lo_w) && (y_w <= hi_w);
    assign hits_inc = (r_hits != '1) ? (r_hits + 1'b1) : r_hits;
    assign slope_c  = CMP_W'(r_slope);
    assign thr_c    = CMP_W'(r_sthr) << FRACTION_BITS;
    assign d_new    = r_t - mul_p;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_hthr  = r_hthr;
        n_sthr  = r_sthr;
        n_tol   = r_tol;
        n_count = r_count;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_sxx   = r_sxx;
        n_sxy   = r_sxy;
        n_pred  = r_pred;
        n_slope = r_slope;
        n_hits  = r_hits;
        n_warn  = r_warn;
        n_y     = r_y;
        n_t     = r_t;
        n_d     = r_d;
        n_an    = r_an;
        n_bn    = r_bn;
        n_out_valid = r_out_valid;
        n_o_warn  = r_o_warn;
        n_o_pred  = r_o_pred;
        n_o_slope = r_o_slope;
        n_o_hits  = r_o_hits;
        n_o_sat   = r_o_sat;

        if (cfg_wr) begin
            case (cfg_idx)
                REG_HIT_THR:   n_hthr = pwdata[HIT_THR_BITS-1:0];
                REG_SLOPE_THR: n_sthr = pwdata[SLOPE_THR_BITS-1:0];
                REG_TOL:       n_tol  = pwdata[TOL_BITS-1:0];
                default:       n_hthr = r_hthr;
            endcase
        end

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_y = i_sample.usage_sample;
                    if (r_pred != '0) begin
                        n_op    = OP_TOLM;
                        n_state = S_RUN;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                if (r_count != '1) begin
                    n_count = x_next;
                    n_sx    = r_sx + SX_W'(x_next);
                    n_sy    = r_sy + SY_W'(r_y);
                    n_op    = OP_XX;
                    n_state = S_RUN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RUN: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (mul_done || div_done) begin
                    n_state = S_RUN;
                    case (r_op)
                        OP_TOLM: begin n_t = mul_p; n_op = OP_TOLD; end
                        OP_TOLD: begin
                            if (hit) begin
                                n_hits = hits_inc;
                                if ((hits_inc > r_hthr) && (slope_c > $signed(thr_c))) begin
                                    n_warn = 1'b1;
                                end
                            end else begin
                                n_hits = '0;
                                n_warn = 1'b0;
                            end
                            n_state = S_UPD;
                        end
                        OP_XX: begin n_sxx = r_sxx + mul_p[SXX_W-1:0]; n_op = OP_XY; end
                        OP_XY: begin n_sxy = r_sxy + mul_p[SXY_W-1:0]; n_op = OP_D1; end
                        OP_D1: begin n_t = mul_p; n_op = OP_D2; end
                        OP_D2: begin
                            n_d = d_new;
                            // zero or negative denominator: slope and prediction keep
                            if ((d_new == '0) || d_new[W-1]) begin
                                n_state = S_OUT;
                            end else begin
                                n_op = OP_A1;
                            end
                        end
                        OP_A1: begin n_t = mul_p; n_op = OP_A2; end
                        OP_A2: begin n_an = d_new; n_op = OP_B1; end
                        OP_B1: begin n_t = mul_p; n_op = OP_B2; end
                        OP_B2: begin n_bn = d_new; n_op = OP_SD; end
                        OP_SD: begin
                            if (div_q >= SLOPE_LIM) begin
                                n_slope = r_an[W-1] ? SLOPE_MIN : SLOPE_MAX;
                            end else if (r_an[W-1]) begin
                                n_slope = -$signed(div_q[SLOPE_BITS-1:0]);
                            end else begin
                                n_slope = $signed(div_q[SLOPE_BITS-1:0]);
                            end
                            n_op = OP_PM;
                        end
                        OP_PM: begin n_t = mul_p + r_bn; n_op = OP_PD; end
                        OP_PD: begin
                            if (r_t[W-1]) begin
                                n_pred = '0;
                            end else if (div_q > SAMPLE_MAX_W) begin
                                n_pred = '1;
                            end else begin
                                n_pred = div_q[SAMPLE_BITS-1:0];
                            end
                            n_state = S_OUT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_o_warn    = r_warn;
                    n_o_pred    = r_pred;
                    n_o_slope   = r_slope;
                    n_o_hits    = r_hits;
                    n_o_sat     = (r_count == '1);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TOLM;
            r_hthr      <= HIT_THR_RST;
            r_sthr      <= SLOPE_THR_RST;
            r_tol       <= TOL_RST;
            r_count     <= '0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sxx       <= '0;
            r_sxy       <= '0;
            r_pred      <= '0;
            r_slope     <= '0;
            r_hits      <= '0;
            r_warn      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_hthr      <= n_hthr;
            r_sthr      <= n_sthr;
            r_tol       <= n_tol;
            r_count     <= n_count;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_sxx       <= n_sxx;
            r_sxy       <= n_sxy;
            r_pred      <= n_pred;
            r_slope     <= n_slope;
            r_hits      <= n_hits;
            r_warn      <= n_warn;
            r_out_valid <= n_out_valid;
        end
        r_y       <= n_y;
        r_t       <= n_t;
        r_d       <= n_d;
        r_an      <= n_an;
        r_bn      <= n_bn;
        r_o_warn  <= n_o_warn;
        r_o_pred  <= n_o_pred;
        r_o_slope <= n_o_slope;
        r_o_hits  <= n_o_hits;
        r_o_sat   <= n_o_sat;
    end

    rrld_mul #(.P_W(W), .B_W(MB_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    rrld_div #(.P_W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    assign o_result.valid           = r_out_valid;
    assign o_result.leak_warning    = r_o_warn;
    assign o_result.predicted_next  = r_o_pred;
    assign o_result.slope_q16       = r_o_slope;
    assign o_result.hit_count       = r_o_hits;
    assign o_result.count_saturated = r_o_sat;
endmodule

@@ rtl/rrld_checker.sv @@
// Port-level checks for the leak detector, bound to the top level.
// Depends on running_regression_leak_detector_defines.svh.
`include "running_regression_leak_detector_defines.svh"

module rrld_checker #(
    parameter int SAMPLE_BITS = 24,
    parameter int SLOPE_BITS  = 41
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_warn,
    input logic [SAMPLE_BITS-1:0] i_pred,
    input logic [SLOPE_BITS-1:0]  i_slope,
    input logic [15:0]            i_hits,
    input logic                   i_sat
);
    // no result right after reset
    `RRLD_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
    // one sample in work at a time
    `RRLD_ASSERT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "second sample taken")
    // a stalled result holds
    `RRLD_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pred) && $stable(i_slope) && $stable(i_hits) && $stable(i_warn) && $stable(i_sat), "stalled result changed")
    // a warning needs at least one hit
    `RRLD_ASSERT(a_warn_hits, i_clk, i_rst_n, i_out_valid && (i_hits == 16'd0) |-> !i_warn, "warning without hits")
endmodule

bind running_regression_leak_detector rrld_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SLOPE_BITS  (SAMPLE_BITS + FRACTION_BITS + 1)
) u_rrld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_warn      (o_result.leak_warning),
    .i_pred      (o_result.predicted_next),
    .i_slope     (o_result.slope_q16),
    .i_hits      (o_result.hit_count),
    .i_sat       (o_result.count_saturated)
);
